// ===== design/fmpia_pkg.sv =====
// Shared constants and types for the pairwise interaction accumulator.
`timescale 1ns / 1ps

package fmpia_pkg;

    localparam int LATENT_DIM   = 32;
    localparam int VALUE_W      = 8;
    localparam int DIM_W        = 5;
    localparam int SUM_W        = 16;
    localparam int TOTAL_W      = 32;
    localparam int RESULT_W     = TOTAL_W + 1;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 40;

    // One element held in the input register.
    typedef struct packed {
        logic signed [VALUE_W-1:0] latent_value;
        logic [DIM_W-1:0]          dimension;
        logic                      final_req;
    } elem_t;

endpackage

// ===== design/fmpia_accum.sv =====
// Per-dimension sums, running totals and result arithmetic.
`timescale 1ns / 1ps

module fmpia_accum
    import fmpia_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  elem_t                      elem,
    output logic signed [RESULT_W-1:0] interaction
);

    logic [SUM_W-1:0]          sums_reg [LATENT_DIM];
    logic [TOTAL_W-1:0]        est_reg;
    logic [TOTAL_W-1:0]        sst_reg;

    logic                      hit;
    logic [SUM_W-1:0]          sum_old;
    logic [SUM_W-1:0]          sum_new;
    logic signed [SUM_W+1:0]   old_s;
    logic signed [SUM_W+1:0]   new_s;
    logic signed [SUM_W+1:0]   diff_s;
    logic signed [SUM_W+1:0]   add_s;
    logic signed [2*SUM_W+3:0] prod;
    logic signed [2*VALUE_W-1:0] x_sq;
    logic [TOTAL_W-1:0]        est_next;
    logic [TOTAL_W-1:0]        sst_next;

    assign hit     = ({1'b0, elem.dimension} < (DIM_W+1)'(LATENT_DIM));
    assign sum_old = sums_reg[elem.dimension];
    assign sum_new = sum_old + {{(SUM_W-VALUE_W){elem.latent_value[VALUE_W-1]}},
                                elem.latent_value};

    // new^2 - old^2 = (new - old) * (new + old), one multiply
    assign old_s  = {{2{sum_old[SUM_W-1]}}, sum_old};
    assign new_s  = {{2{sum_new[SUM_W-1]}}, sum_new};
    assign diff_s = new_s - old_s;
    assign add_s  = new_s + old_s;
    assign prod   = (2*SUM_W+4)'(diff_s) * (2*SUM_W+4)'(add_s);
    assign x_sq   = (2*VALUE_W)'(elem.latent_value) * (2*VALUE_W)'(elem.latent_value);

    assign sst_next = hit ? sst_reg + prod[TOTAL_W-1:0] : sst_reg;
    assign est_next = hit ? est_reg + {{(TOTAL_W-2*VALUE_W){1'b0}}, x_sq} : est_reg;

    assign interaction = $signed({sst_next[TOTAL_W-1], sst_next})
                       - $signed({est_next[TOTAL_W-1], est_next});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_reg <= '0;
            sst_reg <= '0;
            for (int i = 0; i < LATENT_DIM; i++) begin
                sums_reg[i] <= '0;
            end
        end else if (step) begin
            if (elem.final_req) begin
                est_reg <= '0;
                sst_reg <= '0;
                for (int i = 0; i < LATENT_DIM; i++) begin
                    sums_reg[i] <= '0;
                end
            end else begin
                est_reg <= est_next;
                sst_reg <= sst_next;
                if (hit) begin
                    sums_reg[elem.dimension] <= sum_new;
                end
            end
        end
    end

endmodule

// ===== design/fm_pairwise_interaction_accumulator_unit.sv =====
// Usage:
//   Slave side takes one latent-vector element per beat: tdata carries the
//   signed element value and its dimension index, tlast marks the final
//   element of a feature set. Every beat updates its dimension sum and the
//   running squared totals. A tlast beat also produces one master-side beat
//   carrying the 33-bit signed interaction term, after which all sums clear.
//   Non-final beats produce nothing on the master side.
// Timing:
//   The sum read-modify-write and squared-delta multiplier are the single
//   stage between the input register and the output register (m_tvalid);
//   a final beat's result is loaded there as that beat steps. One element per
//   cycle is sustained unless a final beat waits on the output register.
// Reset:
//   aresetn low clears all dimension sums, both totals and both valid flags.
// Backpressure:
//   While a result waits on m_tready, non-final beats keep flowing. A final
//   beat holds in the input register until the output register frees, and
//   s_tready drops only then.
`timescale 1ns / 1ps

module fm_pairwise_interaction_accumulator_unit
    import fmpia_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] latent_value, [12:8] dimension
    input  logic                 s_tlast,   // final_req
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [32:0] interaction
);

    logic                       in_valid_reg;
    elem_t                      elem_reg;
    logic                       m_valid_reg;
    logic signed [RESULT_W-1:0] result_reg;
    logic signed [RESULT_W-1:0] interaction;
    logic                       out_free;
    logic                       step;

    assign out_free = !m_valid_reg || m_tready;
    assign step     = in_valid_reg && (!elem_reg.final_req || out_free);
    assign s_tready = !in_valid_reg || step;

    fmpia_accum u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .elem        (elem_reg),
        .interaction (interaction)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            elem_reg.latent_value <= s_tdata[VALUE_W-1:0];
            elem_reg.dimension    <= s_tdata[VALUE_W+DIM_W-1:VALUE_W];
            elem_reg.final_req    <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step && elem_reg.final_req) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && elem_reg.final_req) begin
            result_reg <= interaction;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RESULT_W){1'b0}}, result_reg};

endmodule

// ===== design/fmpia_checker.sv =====
// Port-level checks for the pairwise interaction accumulator.
`timescale 1ns / 1ps

module fmpia_checker
    import fmpia_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // empty output register never blocks the slave side
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with free output register");

    // pad bits above the result stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:RESULT_W] == '0)
        else $error("nonzero pad bits on m_tdata");

    // a result needs a final beat through both registers
    a_no_early: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_tvalid ##1 !m_tvalid)
        else $error("result right after reset");

endmodule

bind fm_pairwise_interaction_accumulator_unit fmpia_checker u_fmpia_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
